### rtl/assert_macros.svh
// Assertion macros used by the echo top level.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

### rtl/sfe_pkg.sv
// Types and constants of the stereo feedback echo.
// Depends on nothing.
`timescale 1ns / 1ps
package sfe_pkg;
    localparam int RAMP_ONE    = 16777216;
    localparam int TIME_MIN_Q8 = 256;
    localparam int TIME_MAX_Q8 = 512000;
    localparam int GAIN_ONE    = 65536;

    localparam logic [1:0] CFG_RAMP_INC = 2'd0;
    localparam logic [1:0] CFG_SPMS     = 2'd1;
    localparam logic [1:0] CFG_BUF_LEN  = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PARAM  = 1'b1;

    localparam logic [1:0] SEL_TIME = 2'd0;
    localparam logic [1:0] SEL_FB   = 2'd1;
    localparam logic [1:0] SEL_MIX  = 2'd2;

    // Channel lane step codes issued by the sequencer.
    localparam logic [2:0] STEP_IDLE   = 3'd0;
    localparam logic [2:0] STEP_INTERP = 3'd1;
    localparam logic [2:0] STEP_MIX    = 3'd2;
    localparam logic [2:0] STEP_DONE   = 3'd3;

    typedef struct packed {
        logic              opcode;
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
        logic [1:0]        param_select;
        logic [18:0]       param_value;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } out_item_t;

    // Ramp step command from the top to the ramp lanes.
    typedef struct packed {
        logic        advance;
        logic        load;
        logic [18:0] load_value;
    } ramp_ctl_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
        if (x > 48'sd8388607)
            sat24 = 24'sh7FFFFF;
        else if (x < -48'sd8388608)
            sat24 = 24'sh800000;
        else
            sat24 = x[23:0];
    endfunction
endpackage

### rtl/sfe_ramp.sv
// One parameter ramp lane: linear approach of value to target.
// Depends on sfe_pkg. Multiply is registered before the add.
`timescale 1ns / 1ps
module sfe_ramp import sfe_pkg::*; #(
    parameter logic [18:0] RESET_VALUE = 19'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ramp_ctl_t   ctl,
    input  logic [24:0] ramp_increment,
    output logic [18:0] value,
    output logic        busy
);
    logic [18:0] target_reg, start_reg, value_reg;
    logic [24:0] progress_reg;
    logic        pend_reg;
    logic signed [45:0] prod_reg;
    logic [25:0] pr_sum;
    logic signed [19:0] diff;

    assign pr_sum = {1'b0, progress_reg} + {1'b0, ramp_increment};
    assign diff   = $signed({1'b0, target_reg}) - $signed({1'b0, start_reg});
    assign value  = value_reg;
    assign busy   = pend_reg;

    // Load a new ramp, or advance progress: register the product, then add on the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= RESET_VALUE;
            start_reg    <= RESET_VALUE;
            value_reg    <= RESET_VALUE;
            progress_reg <= 25'(RAMP_ONE);
            pend_reg     <= 1'b0;
            prod_reg     <= '0;
        end
        else
        begin
            pend_reg <= 1'b0;
            if (ctl.load)
            begin
                start_reg    <= value_reg;
                target_reg   <= ctl.load_value;
                progress_reg <= '0;
            end
            else if (ctl.advance)
            begin
                if (progress_reg >= 25'(RAMP_ONE) || pr_sum >= 26'(RAMP_ONE))
                begin
                    progress_reg <= 25'(RAMP_ONE);
                    value_reg    <= target_reg;
                end
                else
                begin
                    progress_reg <= pr_sum[24:0];
                    prod_reg     <= 46'(diff * $signed({1'b0, pr_sum[24:0]}));
                    pend_reg     <= 1'b1;
                end
            end
            if (pend_reg)
                value_reg <= 19'($signed({1'b0, start_reg}) + 20'(prod_reg >>> 24));
        end
    end
endmodule

### rtl/sfe_chan.sv
// One audio channel lane: interpolate echo, mix, and compute store value.
// Depends on sfe_pkg. Steps driven by the top-level sequencer.
`timescale 1ns / 1ps
module sfe_chan import sfe_pkg::*; (
    input  logic               clk,
    input  logic [2:0]         step,
    input  logic signed [23:0] a,
    input  logic signed [23:0] b,
    input  logic [7:0]         df,
    input  logic signed [23:0] x,
    input  logic [16:0]        mix,
    input  logic [16:0]        fb,
    output logic signed [23:0] y,
    output logic signed [23:0] store
);
    logic signed [33:0] interp_reg;
    logic signed [42:0] wet_reg, dry_reg, fbp_reg;
    logic signed [23:0] echo;
    logic signed [47:0] outsum, stsum;

    assign echo   = interp_reg[31:8];
    assign outsum = 48'(wet_reg + dry_reg) >>> 16;
    assign stsum  = 48'(x) + 48'(fbp_reg >>> 16);

    // Run the lane arithmetic one registered stage per step.
    always_ff @(posedge clk)
    begin
        case (step)
            STEP_INTERP:
                interp_reg <= 34'(a * $signed({1'b0, df})
                              + b * $signed(10'd256 - {2'b0, df}));
            STEP_MIX:
            begin
                wet_reg <= 43'(echo * $signed({1'b0, mix}));
                dry_reg <= 43'(x * $signed(18'(GAIN_ONE) - {1'b0, mix}));
                fbp_reg <= 43'(echo * $signed({1'b0, fb}));
            end
            STEP_DONE:
            begin
                y     <= sat24(outsum);
                store <= sat24(stsum);
            end
            default: ;
        endcase
    end
endmodule

### rtl/stereo_feedback_echo.sv
// Stereo feedback echo: one sample transaction passes through a sequencer
// whose steps are ramp advance, ramp add, delay multiply, two memory reads,
// interpolation, mix, saturation and write-back; the single-port delay memory
// and the registered ramp multiply set these steps. The result is valid the cycle
// after write-back and the next transaction is taken the cycle after the result
// is accepted, so no new sample is taken while a result is still pending.
// Parameter transactions produce no output. After reset the delay memory is
// cleared one entry per cycle until all MAX_DELAY_ENTRIES entries are zero,
// and no transaction is accepted while it is cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stereo_feedback_echo import sfe_pkg::*; #(
    parameter int MAX_DELAY_ENTRIES = 131072
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [24:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam int AW = $clog2(MAX_DELAY_ENTRIES);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001, S_IDLE = 11'b00000000010, S_RAMP = 11'b00000000100,
        S_TWAIT = 11'b00000001000, S_DEL  = 11'b00000010000, S_RDB  = 11'b00000100000,
        S_RDA   = 11'b00001000000, S_INT  = 11'b00010000000, S_MIX  = 11'b00100000000,
        S_SAT   = 11'b01000000000, S_WR   = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [24:0] inc_reg;
    logic [15:0] spms_reg;
    logic [17:0] blen_reg;
    logic [AW:0] len, wp_reg, bi_reg, ai, clr_reg, bi_c;
    logic [AW:0] di;
    logic [7:0]  df_reg;
    logic [35:0] dq_reg;
    logic [35:0] dmax;
    in_item_t    item_reg;
    logic [47:0] mem [MAX_DELAY_ENTRIES];
    logic [47:0] rd_reg, b_reg;
    logic [18:0] tval, fbv, mixv;
    logic        tbusy, fbusy, mbusy;
    ramp_ctl_t   ctl_t, ctl_f, ctl_m;
    logic [18:0] pval;
    logic signed [23:0] yl, yr, stl, str;
    logic [2:0]  step;
    logic [35:0] dq_c;
    logic        par_acc;

    // Clamp length in use.
    always_comb
    begin
        if (blen_reg < 18'd2)
            len = (AW+1)'(2);
        else if (32'(blen_reg) > MAX_DELAY_ENTRIES)
            len = (AW+1)'(MAX_DELAY_ENTRIES);
        else
            len = (AW+1)'(blen_reg);
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign par_acc  = in_valid && in_ready && in_data.opcode == OP_PARAM;

    // Clamp parameter target.
    always_comb
    begin
        pval = in_data.param_value;
        if (in_data.param_select == SEL_TIME)
        begin
            if (pval < 19'(TIME_MIN_Q8)) pval = 19'(TIME_MIN_Q8);
            if (pval > 19'(TIME_MAX_Q8)) pval = 19'(TIME_MAX_Q8);
        end
        else if (pval > 19'(GAIN_ONE))
            pval = 19'(GAIN_ONE);
    end

    assign ctl_t = '{advance: state_reg == S_RAMP,
                     load: par_acc && in_data.param_select == SEL_TIME, load_value: pval};
    assign ctl_f = '{advance: state_reg == S_RAMP,
                     load: par_acc && in_data.param_select == SEL_FB, load_value: pval};
    assign ctl_m = '{advance: state_reg == S_RAMP,
                     load: par_acc && in_data.param_select == SEL_MIX, load_value: pval};

    sfe_ramp #(.RESET_VALUE(19'd76800)) u_time (.clk, .rst_n, .ctl(ctl_t),
        .ramp_increment(inc_reg), .value(tval), .busy(tbusy));
    sfe_ramp #(.RESET_VALUE(19'd32768)) u_fb (.clk, .rst_n, .ctl(ctl_f),
        .ramp_increment(inc_reg), .value(fbv), .busy(fbusy));
    sfe_ramp #(.RESET_VALUE(19'd32768)) u_mix (.clk, .rst_n, .ctl(ctl_m),
        .ramp_increment(inc_reg), .value(mixv), .busy(mbusy));

    assign dmax = 36'(len - 1'b1) << 8;
    assign dq_c = (dq_reg < 36'd256) ? 36'd256 : ((dq_reg > dmax) ? dmax : dq_reg);
    assign di   = (AW+1)'(dq_c >> 8);
    assign bi_c = (wp_reg + len - di >= len) ? wp_reg - di : wp_reg + len - di;
    assign ai   = (bi_reg == '0) ? len - 1'b1 : bi_reg - 1'b1;

    always_comb
    begin
        unique case (state_reg)
            S_INT:   step = STEP_INTERP;
            S_MIX:   step = STEP_MIX;
            S_SAT:   step = STEP_DONE;
            default: step = STEP_IDLE;
        endcase
    end

    sfe_chan u_left (.clk, .step, .a(rd_reg[47:24]), .b(b_reg[47:24]), .df(df_reg),
        .x(item_reg.left_in), .mix(mixv[16:0]), .fb(fbv[16:0]), .y(yl), .store(stl));
    sfe_chan u_right (.clk, .step, .a(rd_reg[23:0]), .b(b_reg[23:0]), .df(df_reg),
        .x(item_reg.right_in), .mix(mixv[16:0]), .fb(fbv[16:0]), .y(yr), .store(str));

    // Delay memory: one access per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg[AW-1:0]] <= '0;
        else if (state_reg == S_WR)
            mem[wp_reg[AW-1:0]] <= {stl, str};
        else if (state_reg == S_RDB)
            rd_reg <= mem[bi_c[AW-1:0]];
        else if (state_reg == S_RDA)
            rd_reg <= mem[ai[AW-1:0]];
        if (state_reg == S_RDA)
            b_reg <= rd_reg;
    end

    // Latch the result at write-back.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
        begin
            out_data.left_out  <= yl;
            out_data.right_out <= yr;
        end
    end

    // Sequencer, configuration and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            inc_reg   <= 25'd3495;
            spms_reg  <= 16'd12288;
            blen_reg  <= 18'd96000;
            wp_reg    <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RAMP_INC: inc_reg  <= cfg_data;
                    CFG_SPMS:     spms_reg <= cfg_data[15:0];
                    CFG_BUF_LEN:  blen_reg <= cfg_data[17:0];
                    default: ;
                endcase
            end
            if (state_reg == S_WR)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MAX_DELAY_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_valid && in_ready && in_data.opcode == OP_SAMPLE)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_RAMP;
                        if (wp_reg >= len) wp_reg <= '0;
                    end
                S_RAMP:  state_reg <= S_TWAIT;
                S_TWAIT: state_reg <= S_DEL;
                S_DEL:
                begin
                    dq_reg    <= 36'((tval * spms_reg) >> 8);
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    df_reg    <= dq_c[7:0];
                    bi_reg    <= bi_c;
                    state_reg <= S_RDA;
                end
                S_RDA: state_reg <= S_INT;
                S_INT: state_reg <= S_MIX;
                S_MIX: state_reg <= S_SAT;
                S_SAT: state_reg <= S_WR;
                S_WR:
                begin
                    wp_reg    <= (wp_reg + 1'b1 >= len) ? '0 : wp_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `CHK_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `CHK_IMPL(a_ramp_settled, clk, rst_n, state_reg == S_DEL, !(tbusy || fbusy || mbusy))
endmodule
